@@ rtl/padl_pkg.sv @@
`default_nettype none
package padl_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LEN_W     = 33;
  localparam int RAD_W     = 2 * LEN_W;
  localparam int RATIO_W   = 32 + FRAC_BITS;
  localparam int CHUNK_W   = 16;
  localparam int NCH       = (RATIO_W + CHUNK_W - 1) / CHUNK_W;
  localparam int RATIO_PAD = NCH * CHUNK_W;
  localparam int ACC_W     = RAD_W;
  localparam int OFF_W     = 64 - FRAC_BITS;
  localparam int SUM_W     = OFF_W + 2;
  localparam int SQ_ISSUES = 4;
  localparam int KMAX      = (NCH + 1 > SQ_ISSUES + 1) ? NCH + 1 : SQ_ISSUES + 1;
  localparam int KCNT_W    = $clog2(KMAX + 1);

  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_SHORT  = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic               path_start;
    logic               path_end;
    logic               path_empty;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_speed_x;
    logic signed [31:0] out_speed_y;
    logic [1:0]         status;
  } out_beat_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SQ   = 6'b000010,
    S_ROOT = 6'b000100,
    S_DIV  = 6'b001000,
    S_LERP = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

endpackage
`default_nettype wire

@@ rtl/polyline_point_at_distance_top.sv @@
`default_nettype none
// Returns the point at the lookahead arc length along a path that arrives one point per beat,
// at most one result beat per path. A new point is taken only after the previous one is
// finished. A point that adds no segment (a start mark, an empty mark, or any point after the
// path's result) is taken with no arithmetic. A point that adds a segment holds the input through
// the accepting cycle, the squares on a shared 33x17 multiplier and the bit-serial square root
// and its handoff. The segment that passes the lookahead distance adds a restoring division
// (none for a zero-length segment) and an interpolation on the same multiplier. A point that
// yields a result then loads the output register, and waits to do so while the previous result
// beat is still waiting.
module polyline_point_at_distance_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  padl_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output padl_pkg::out_beat_t  out_data,
  input  logic                 cfg_we,
  input  logic [30:0]          cfg_data
);
  import padl_pkg::*;

  state_t               state_r;
  logic [30:0]          la_r;
  logic signed [31:0]   prev_r [4];
  logic signed [31:0]   cur_r [4];
  logic signed [31:0]   res_r [3];
  logic                 end_r;
  logic [31:0]          run_r;
  logic                 answered_r;
  logic [LEN_W-1:0]     a_r;
  logic [LEN_W-1:0]     b_r;
  logic [RATIO_PAD-1:0] ratio_r;
  logic [KCNT_W-1:0]    k_r;
  logic [1:0]           c_r;
  logic [ACC_W-1:0]     acc_r;
  logic [LEN_W+16:0]    prod_r;
  logic [5:0]           sh_r;
  logic                 pv_r;
  out_beat_t            pend_r;
  out_beat_t            out_r;
  logic                 out_valid_r;

  logic [LEN_W-1:0]     opa;
  logic [16:0]          opb;
  logic [LEN_W-1:0]     sqx;
  logic [5:0]           shn;
  logic                 issue;
  logic signed [32:0]   dx;
  logic signed [32:0]   dy;
  logic signed [31:0]   prevc;
  logic signed [31:0]   curc;
  logic signed [32:0]   dl;
  logic [LEN_W-1:0]     mag;
  logic [63:0]          rnd;
  logic [OFF_W-1:0]     off;
  logic signed [SUM_W-1:0] lsum;
  logic signed [31:0]   lres;
  logic                 sq_go;
  logic                 sq_done;
  logic [LEN_W-1:0]     sq_root;
  logic                 dv_go;
  logic                 dv_done;
  logic [RATIO_W-1:0]   dv_q;
  logic [33:0]          rsum;
  logic [31:0]          runn;
  logic [31:0]          dover;
  logic                 acc_clr;
  logic                 load_out;

  assign dx = $signed({in_data.point_x[31], in_data.point_x}) - $signed({prev_r[0][31], prev_r[0]});
  assign dy = $signed({in_data.point_y[31], in_data.point_y}) - $signed({prev_r[1][31], prev_r[1]});

  assign prevc = prev_r[c_r];
  assign curc  = cur_r[c_r];
  assign dl    = $signed({prevc[31], prevc}) - $signed({curc[31], curc});
  assign mag   = dl[32] ? LEN_W'(-dl) : LEN_W'(dl);

  always_comb begin
    opa   = '0;
    opb   = '0;
    shn   = '0;
    issue = 1'b0;
    sqx   = k_r[1] ? b_r : a_r;
    case (state_r)
      S_SQ: begin
        opa   = sqx;
        opb   = k_r[0] ? {1'b0, sqx[LEN_W-1:17]} : sqx[16:0];
        shn   = k_r[0] ? 6'd17 : 6'd0;
        issue = k_r < KCNT_W'(SQ_ISSUES);
      end
      S_LERP: begin
        opa = mag;
        for (int i = 0; i < NCH; i++) begin
          if (k_r == KCNT_W'(i)) opb = {1'b0, ratio_r[i*CHUNK_W +: CHUNK_W]};
        end
        shn   = 6'(k_r * CHUNK_W);
        issue = k_r < KCNT_W'(NCH);
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  assign rnd  = acc_r[63:0] + 64'(1 << (FRAC_BITS - 1));
  assign off  = rnd[63:FRAC_BITS];
  assign lsum = dl[32] ? SUM_W'(curc) - $signed({2'b00, off})
                       : SUM_W'(curc) + $signed({2'b00, off});
  always_comb begin
    if (!lsum[SUM_W-1] && (|lsum[SUM_W-2:31])) lres = 32'sh7fffffff;
    else if (lsum[SUM_W-1] && !(&lsum[SUM_W-2:31])) lres = 32'sh80000000;
    else lres = lsum[31:0];
  end

  assign sq_go = (state_r == S_SQ) && (k_r == KCNT_W'(SQ_ISSUES + 1));
  assign rsum  = {2'b00, run_r} + {1'b0, sq_root};
  assign runn  = (|rsum[33:32]) ? 32'hffffffff : rsum[31:0];
  assign dover = runn - {1'b0, la_r};
  assign dv_go = (state_r == S_ROOT) && sq_done && (runn > {1'b0, la_r}) && (|sq_root);

  assign acc_clr  = !((state_r == S_SQ) ||
                      ((state_r == S_LERP) && (k_r != KCNT_W'(NCH + 1))));
  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_ready);

  padl_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_go),
    .radicand (acc_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  padl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_go),
    .dividend ({dover, FRAC_BITS'(0)}),
    .divisor  (sq_root),
    .done     (dv_done),
    .quotient (dv_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      la_r        <= '0;
      run_r       <= '0;
      answered_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      for (int i = 0; i < 4; i++) prev_r[i] <= '0;
    end else begin
      if (cfg_we) la_r <= cfg_data;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      prod_r <= opa * opb;
      sh_r   <= shn;
      pv_r   <= issue;
      if (acc_clr) acc_r <= '0;
      else if (pv_r) acc_r <= acc_r + (ACC_W'(prod_r) << sh_r);
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.path_empty) begin
              pend_r     <= '{out_x: {1'b0, la_r}, out_y: '0, out_speed_x: '0,
                              out_speed_y: '0, status: ST_EMPTY};
              for (int i = 0; i < 4; i++) prev_r[i] <= '0;
              run_r      <= '0;
              answered_r <= 1'b1;
              state_r    <= S_OUT;
            end else begin
              if (in_data.path_start || answered_r) begin
                prev_r[0] <= in_data.point_x;
                prev_r[1] <= in_data.point_y;
                prev_r[2] <= in_data.speed_x;
                prev_r[3] <= in_data.speed_y;
              end
              if (in_data.path_start) begin
                run_r      <= '0;
                answered_r <= in_data.path_end;
                if (in_data.path_end) begin
                  pend_r  <= '{out_x: in_data.point_x, out_y: in_data.point_y,
                               out_speed_x: in_data.speed_x, out_speed_y: in_data.speed_y,
                               status: ST_SHORT};
                  state_r <= S_OUT;
                end
              end else if (!answered_r) begin
                cur_r[0] <= in_data.point_x;
                cur_r[1] <= in_data.point_y;
                cur_r[2] <= in_data.speed_x;
                cur_r[3] <= in_data.speed_y;
                end_r    <= in_data.path_end;
                a_r      <= dx[32] ? LEN_W'(-dx) : LEN_W'(dx);
                b_r      <= dy[32] ? LEN_W'(-dy) : LEN_W'(dy);
                k_r      <= '0;
                state_r  <= S_SQ;
              end
            end
          end
        end
        S_SQ: begin
          k_r <= k_r + KCNT_W'(1);
          if (sq_go) state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (sq_done) begin
            run_r <= runn;
            if (runn > {1'b0, la_r}) begin
              if (dv_go) begin
                state_r <= S_DIV;
              end else begin
                ratio_r <= '0;
                k_r     <= '0;
                c_r     <= '0;
                state_r <= S_LERP;
              end
            end else begin
              prev_r <= cur_r;
              if (end_r) begin
                pend_r     <= '{out_x: cur_r[0], out_y: cur_r[1], out_speed_x: cur_r[2],
                                out_speed_y: cur_r[3], status: ST_SHORT};
                answered_r <= 1'b1;
                state_r    <= S_OUT;
              end else begin
                state_r <= S_IDLE;
              end
            end
          end
        end
        S_DIV: begin
          if (dv_done) begin
            ratio_r <= RATIO_PAD'(dv_q);
            k_r     <= '0;
            c_r     <= '0;
            state_r <= S_LERP;
          end
        end
        S_LERP: begin
          if (k_r == KCNT_W'(NCH + 1)) begin
            k_r <= '0;
            c_r <= c_r + 2'd1;
            if (c_r == 2'd3) begin
              pend_r     <= '{out_x: res_r[0], out_y: res_r[1], out_speed_x: res_r[2],
                              out_speed_y: lres, status: ST_INTERP};
              answered_r <= 1'b1;
              prev_r     <= cur_r;
              state_r    <= S_OUT;
            end else begin
              res_r[c_r] <= lres;
            end
          end else begin
            k_r <= k_r + KCNT_W'(1);
          end
        end
        S_OUT: begin
          if (load_out) begin
            out_r   <= pend_r;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_sqrt_in_root: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == S_ROOT) else $error("root finished outside its state");

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    dv_done |-> state_r == S_DIV) else $error("divide finished outside its state");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_INTERP || out_data.status == ST_SHORT ||
                   out_data.status == ST_EMPTY)) else $error("bad status code");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_data.path_empty && !in_data.path_start && !answered_r)
    |=> !in_ready) else $error("second beat taken while busy");

endmodule
`default_nettype wire

@@ rtl/padl_sqrt.sv @@
`default_nettype none
module padl_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [padl_pkg::RAD_W-1:0] radicand,
  output logic                       done,
  output logic [padl_pkg::LEN_W-1:0] root
);
  import padl_pkg::*;

  logic [RAD_W-1:0] rad_r;
  logic [LEN_W+1:0] rem_r;
  logic [LEN_W-1:0] root_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [LEN_W+3:0] rem2;
  logic [LEN_W+3:0] trial;
  logic             fit;

  assign rem2  = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign fit   = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        rem_r  <= fit ? (LEN_W+2)'(rem2 - trial) : (LEN_W+2)'(rem2);
        root_r <= {root_r[LEN_W-2:0], fit};
        cnt_r  <= cnt_r + 6'd1;
        if (cnt_r == 6'(LEN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          done_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

@@ rtl/padl_div.sv @@
`default_nettype none
module padl_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [padl_pkg::RATIO_W-1:0] dividend,
  input  logic [padl_pkg::LEN_W-1:0]   divisor,
  output logic                         done,
  output logic [padl_pkg::RATIO_W-1:0] quotient
);
  import padl_pkg::*;

  localparam int CNT_W = $clog2(RATIO_W + 1);

  logic [RATIO_W-1:0] q_r;
  logic [LEN_W:0]     rem_r;
  logic [LEN_W-1:0]   div_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [LEN_W+1:0]   rem2;
  logic               fit;

  assign rem2 = {rem_r, q_r[RATIO_W-1]};
  assign fit  = rem2 >= {2'b00, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        q_r    <= dividend;
        div_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end else if (busy_r) begin
        rem_r <= fit ? (LEN_W+1)'(rem2 - {2'b00, div_r}) : (LEN_W+1)'(rem2);
        q_r   <= {q_r[RATIO_W-2:0], fit};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(RATIO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          done_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire
